// ===== rtl/nrbh_pkg.sv =====
// Shared types and constants for the nearest ray/box hit block.
// No dependencies; imported by every module under rtl/.
package nrbh_pkg;

  localparam int unsigned SlotsDef = 64;
  localparam int unsigned TileW    = 15;
  localparam logic [TileW-1:0] TileRst = 15'd256;

  localparam int unsigned NumW  = 20;
  localparam int unsigned DenW  = 17;
  localparam int unsigned ProdW = NumW + DenW + 1;

  localparam int unsigned QuoW  = 17;
  localparam int unsigned DivDW = 18;
  localparam int unsigned DivMW = DivDW + QuoW;
  localparam int unsigned DivNW = DivMW + 1;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    NRM_NONE = 3'd0,
    NRM_XN   = 3'd1,
    NRM_XP   = 3'd2,
    NRM_ZN   = 3'd3,
    NRM_ZP   = 3'd4
  } normal_e;

  typedef struct packed {
    logic              req_type;
    logic [5:0]        slot_index;
    logic              slot_live;
    logic signed [15:0] box_x;
    logic signed [15:0] box_z;
    logic signed [7:0]  floor_id;
    logic signed [15:0] start_x;
    logic signed [15:0] start_z;
    logic signed [15:0] end_x;
    logic signed [15:0] end_z;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [5:0]        hit_slot;
    logic [16:0]       hit_t;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_z;
    logic [2:0]        normal_code;
  } out_t;

  typedef struct packed {
    logic              live;
    logic signed [15:0] x;
    logic signed [15:0] z;
    logic signed [7:0]  floor_lvl;
  } box_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sz;
    logic signed [16:0] dx;
    logic signed [16:0] dz;
    logic signed [7:0]  floor_lvl;
  } query_t;

  typedef struct packed {
    logic            found;
    logic [DenW-1:0] n;
    logic [DenW-1:0] d;
    normal_e         norm;
  } best_t;

endpackage

// ===== rtl/nrbh_cell.sv =====
// One box slot of the storage ring: live flag plus center and floor.
// Depends on nrbh_pkg.
module nrbh_cell
  import nrbh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  box_t wr_box_i,
  input  logic shift_i,
  input  box_t nbr_i,
  output box_t box_o
);

  logic live_q;
  box_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (wr_i) begin
      live_q <= wr_box_i.live;
    end else if (shift_i) begin
      live_q <= nbr_i.live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      data_q <= wr_box_i;
    end else if (shift_i) begin
      data_q <= nbr_i;
    end
  end

  always_comb begin
    box_o      = data_q;
    box_o.live = live_q;
  end

endmodule

// ===== rtl/nrbh_slab.sv =====
// Pipelined slab test on the box at the ring head, plus nearest-hit tracker.
// Depends on nrbh_pkg.
module nrbh_slab
  import nrbh_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  issue_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_i,
  input  box_t                  box_i,
  input  query_t                qry_i,
  input  logic [TileW-1:0]      tile_i,
  output logic                  busy_o,
  output best_t                 best_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] best_slot_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic                   ok;
    logic                   nz;
    logic                   upd_min;
    logic                   upd_max;
    logic signed [NumW-1:0] en;
    logic signed [NumW-1:0] ex;
    logic [DenW-1:0]        den;
    normal_e                code;
  } axis_t;

  function automatic axis_t axis_eval(input logic signed [15:0] s,
                                      input logic signed [15:0] c,
                                      input logic signed [16:0] d,
                                      input logic [TileW-1:0] tile,
                                      input normal_e lo_code,
                                      input normal_e hi_code);
    axis_t r;
    logic signed [NumW-1:0] s2, c2, t2, lo, hi, n1, n2, m1, m2;
    logic signed [17:0] d2;
    logic neg, swap;
    s2 = {{(NumW-17){s[15]}}, s, 1'b0};
    c2 = {{(NumW-17){c[15]}}, c, 1'b0};
    t2 = {{(NumW-TileW){1'b0}}, tile};
    d2 = {d, 1'b0};
    lo = c2 - t2;
    hi = c2 + t2;
    n1 = lo - s2;
    n2 = hi - s2;
    neg = d2[17];
    m1 = neg ? -n1 : n1;
    m2 = neg ? -n2 : n2;
    swap = m1 > m2;
    r.nz   = (d2 != '0);
    r.en   = swap ? m2 : m1;
    r.ex   = swap ? m1 : m2;
    r.code = swap ? hi_code : lo_code;
    r.den  = DenW'(neg ? -d2 : d2);
    r.ok   = r.nz || ((n1[NumW-1] || (n1 == '0)) && !n2[NumW-1]);
    r.upd_min = r.nz && !r.en[NumW-1] && (r.en != '0);
    r.upd_max = r.nz && (r.ex < $signed({{(NumW-DenW){1'b0}}, r.den}));
    return r;
  endfunction

  function automatic logic signed [ProdW-1:0] mulnd(input logic signed [NumW-1:0] n,
                                                    input logic [DenW-1:0] d);
    logic signed [ProdW-1:0] a, b;
    a = ProdW'(n);
    b = ProdW'($signed({1'b0, d}));
    return a * b;
  endfunction

  axis_t ax, az;
  logic  match;

  assign ax    = axis_eval(qry_i.sx, box_i.x, qry_i.dx, tile_i, NRM_XN, NRM_XP);
  assign az    = axis_eval(qry_i.sz, box_i.z, qry_i.dz, tile_i, NRM_ZN, NRM_ZP);
  assign match = box_i.live && (box_i.floor_lvl == qry_i.floor_lvl);

  // stage 1: per-axis entry/exit
  logic                   v1_q, ok1_q;
  logic [IdxW-1:0]        slot1_q;
  logic signed [NumW-1:0] mn_n1_q, mx_n1_q;
  logic [DenW-1:0]        mn_d1_q, mx_d1_q;
  normal_e                nrm1_q;
  axis_t                  z1_q;

  // stage 2: cross products for z slab
  logic                    v2_q, ok2_q;
  logic [IdxW-1:0]         slot2_q;
  logic signed [NumW-1:0]  mn_n2_q, mx_n2_q;
  logic [DenW-1:0]         mn_d2_q, mx_d2_q;
  normal_e                 nrm2_q;
  axis_t                   z2_q;
  logic signed [ProdW-1:0] pa_q, pb_q, pc_q, pe_q;

  // stage 3: merged interval
  logic                   v3_q, ok3_q;
  logic [IdxW-1:0]        slot3_q;
  logic signed [NumW-1:0] mn_n3_q, mx_n3_q;
  logic [DenW-1:0]        mn_d3_q, mx_d3_q;
  normal_e                nrm3_q;

  logic            found_q;
  logic [DenW-1:0] best_n_q, best_d_q;
  normal_e         best_nrm_q;
  logic [IdxW-1:0] best_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    slot1_q <= slot_i;
    ok1_q   <= match && ax.ok && az.ok;
    mn_n1_q <= ax.upd_min ? ax.en : '0;
    mn_d1_q <= ax.upd_min ? ax.den : DenW'(1);
    nrm1_q  <= ax.upd_min ? ax.code : NRM_NONE;
    mx_n1_q <= ax.upd_max ? ax.ex : NumW'(1);
    mx_d1_q <= ax.upd_max ? ax.den : DenW'(1);
    z1_q    <= az;

    slot2_q <= slot1_q;
    ok2_q   <= ok1_q;
    mn_n2_q <= mn_n1_q;
    mn_d2_q <= mn_d1_q;
    nrm2_q  <= nrm1_q;
    mx_n2_q <= mx_n1_q;
    mx_d2_q <= mx_d1_q;
    z2_q    <= z1_q;
    pa_q    <= mulnd(z1_q.en, mn_d1_q);
    pb_q    <= mulnd(mn_n1_q, z1_q.den);
    pc_q    <= mulnd(z1_q.ex, mx_d1_q);
    pe_q    <= mulnd(mx_n1_q, z1_q.den);

    slot3_q <= slot2_q;
    ok3_q   <= ok2_q;
    if (z2_q.nz && (pa_q > pb_q)) begin
      mn_n3_q <= z2_q.en;
      mn_d3_q <= z2_q.den;
      nrm3_q  <= z2_q.code;
    end else begin
      mn_n3_q <= mn_n2_q;
      mn_d3_q <= mn_d2_q;
      nrm3_q  <= nrm2_q;
    end
    if (z2_q.nz && (pc_q < pe_q)) begin
      mx_n3_q <= z2_q.ex;
      mx_d3_q <= z2_q.den;
    end else begin
      mx_n3_q <= mx_n2_q;
      mx_d3_q <= mx_d2_q;
    end
  end

  // stage 4: interval check and nearest-so-far compare
  logic signed [ProdW-1:0] p1, p2, q1, q2;
  logic                    hit, take;

  assign p1   = mulnd(mx_n3_q, mn_d3_q);
  assign p2   = mulnd(mn_n3_q, mx_d3_q);
  assign q1   = mulnd(mn_n3_q, best_d_q);
  assign q2   = mulnd($signed({{(NumW-DenW){1'b0}}, best_n_q}), mn_d3_q);
  assign hit  = v3_q && ok3_q && !(p1 < p2);
  assign take = hit && (!found_q || (q1 < q2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clr_i) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_n_q    <= DenW'(mn_n3_q);
      best_d_q    <= mn_d3_q;
      best_nrm_q  <= nrm3_q;
      best_slot_q <= slot3_q;
    end
  end

  always_comb begin
    best_o.found = found_q;
    best_o.n     = best_n_q;
    best_o.d     = best_d_q;
    best_o.norm  = best_nrm_q;
  end

  assign busy_o      = v1_q || v2_q || v3_q;
  assign best_slot_o = best_slot_q;

endmodule

// ===== rtl/nrbh_div.sv =====
// Restoring divider, one quotient bit per cycle, floor semantics on signed
// numerator. Depends on nrbh_pkg.
module nrbh_div
  import nrbh_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DivNW-1:0] num_i,
  input  logic [DivDW-1:0]        den_i,
  output logic                    busy_o,
  output logic signed [QuoW:0]    quo_o
);

  localparam int unsigned CntW = $clog2(QuoW + 1);

  logic             busy_q, neg_q;
  logic [CntW-1:0]  cnt_q;
  logic [DivDW-1:0] rem_q, den_q;
  logic [QuoW-1:0]  lo_q;
  logic [DivMW-1:0] mag;
  logic [DivDW:0]   trial, diff;
  logic             fits;

  assign mag   = num_i[DivNW-1] ? DivMW'(~num_i) : DivMW'(num_i);
  assign trial = {rem_q, lo_q[QuoW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(QuoW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DivNW-1];
      rem_q <= mag[DivMW-1:QuoW];
      lo_q  <= mag[QuoW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DivDW'(diff) : DivDW'(trial);
      lo_q  <= {lo_q[QuoW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? ~$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});

endmodule

// ===== rtl/nearest_ray_box_hit.sv =====
// Top level: box storage ring, slab pipeline, hit-point dividers and control.
// Depends on nrbh_pkg, nrbh_cell, nrbh_slab, nrbh_div.
//
//  channel  | signals                          | dir | payload
//  ---------+----------------------------------+-----+---------------------
//  in       | in_valid_i / in_ready_o          | in  | in_t (write or query)
//  out      | out_valid_o / out_ready_i        | out | out_t (one per item)
//  cfg      | cfg_valid_i / cfg_ready_o        | in  | box edge length, 15 bits
//
// Write transaction: goes straight through S_RES to the output register.
// Query: rotates the ring past the slab pipeline, drains it, forms the hit-point
// products and runs the dividers (skipped on a miss), then goes to output.
// Zero-length ray skips the scan. Reset clears live flags at once, no sweep.
// A result held by out_ready_i low stalls the core only after the next item.
module nearest_ray_box_hit
  import nrbh_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [TileW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DIVS  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_RES   = 7'b1000000
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [15:0] s,
                                               input logic signed [QuoW:0] q);
    logic signed [18:0] sum;
    sum = 19'(s) + 19'(q);
    if (sum > 19'sd32767) begin
      return 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      return 16'sh8000;
    end
    return 16'(sum);
  endfunction

  state_e           state_q, state_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [TileW-1:0] tile_q;
  query_t           qry_q, qry_d;
  out_t             res_q, res_d, out_q;
  logic             out_valid_q;
  logic signed [34:0] px_q, pz_q;

  logic   acc, wr_acc, q_acc, zero_ray, shift, clr, start;
  box_t   wr_box;
  box_t   cell_box [SLOTS];
  logic [SLOTS-1:0] cell_we;
  logic   slab_busy;
  best_t  best;
  logic [IdxW-1:0] best_slot;
  logic   bt_busy, bx_busy, bz_busy;
  logic signed [QuoW:0] qt, qx, qz;
  logic signed [DivNW-1:0] nt, nx, nz;
  logic [DivDW-1:0] dd;
  logic signed [17:0] n_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i && in_ready_o;
  assign wr_acc      = acc && (in_data_i.req_type == REQ_WRITE);
  assign q_acc       = acc && (in_data_i.req_type == REQ_QUERY);
  assign shift       = (state_q == S_SCAN);
  assign clr         = q_acc;
  assign start       = (state_q == S_DIVS);

  always_comb begin
    wr_box.live      = in_data_i.slot_live;
    wr_box.x         = in_data_i.box_x;
    wr_box.z         = in_data_i.box_z;
    wr_box.floor_lvl = in_data_i.floor_id;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign cell_we[i] = wr_acc && (32'(in_data_i.slot_index) == 32'(i));
    nrbh_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (cell_we[i]),
      .wr_box_i (wr_box),
      .shift_i  (shift),
      .nbr_i    (cell_box[(i + 1) % SLOTS]),
      .box_o    (cell_box[i])
    );
  end

  nrbh_slab #(
    .SLOTS (SLOTS)
  ) u_slab (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (clr),
    .issue_i     (shift),
    .slot_i      (cnt_q),
    .box_i       (cell_box[0]),
    .qry_i       (qry_q),
    .tile_i      (tile_q),
    .busy_o      (slab_busy),
    .best_o      (best),
    .best_slot_o (best_slot)
  );

  assign n_ext = $signed({1'b0, best.n});
  assign nt    = $signed({2'b00, best.n, 17'd0}) + $signed({19'd0, best.d});
  assign nx    = (DivNW'(px_q) <<< 1) + $signed({19'd0, best.d});
  assign nz    = (DivNW'(pz_q) <<< 1) + $signed({19'd0, best.d});
  assign dd    = {best.d, 1'b0};

  nrbh_div u_div_t (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .num_i (nt), .den_i (dd), .busy_o (bt_busy), .quo_o (qt)
  );
  nrbh_div u_div_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .num_i (nx), .den_i (dd), .busy_o (bx_busy), .quo_o (qx)
  );
  nrbh_div u_div_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .num_i (nz), .den_i (dd), .busy_o (bz_busy), .quo_o (qz)
  );

  assign zero_ray = (in_data_i.end_x == in_data_i.start_x) &&
                    (in_data_i.end_z == in_data_i.start_z);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    qry_d   = qry_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          qry_d.sx        = in_data_i.start_x;
          qry_d.sz        = in_data_i.start_z;
          qry_d.dx        = $signed({in_data_i.end_x[15], in_data_i.end_x}) -
                            $signed({in_data_i.start_x[15], in_data_i.start_x});
          qry_d.dz        = $signed({in_data_i.end_z[15], in_data_i.end_z}) -
                            $signed({in_data_i.start_z[15], in_data_i.start_z});
          qry_d.floor_lvl = in_data_i.floor_id;
          res_d           = '0;
          cnt_d           = '0;
          state_d         = (wr_acc || zero_ray) ? S_RES : S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == IdxW'(SLOTS - 1)) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      S_DRAIN: begin
        if (!slab_busy) begin
          state_d = best.found ? S_MUL : S_RES;
        end
      end
      S_MUL: begin
        state_d = S_DIVS;
      end
      S_DIVS: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!bt_busy && !bx_busy && !bz_busy) begin
          res_d.hit         = 1'b1;
          res_d.hit_slot    = 6'(best_slot);
          res_d.hit_t       = 17'(qt);
          res_d.hit_x       = sat16(qry_q.sx, qx);
          res_d.hit_z       = sat16(qry_q.sz, qz);
          res_d.normal_code = 3'(best.norm);
          state_d           = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tile_q      <= TileRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        tile_q <= cfg_data_i;
      end
      if ((state_q == S_RES) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q <= qry_d;
    res_q <= res_d;
    if (state_q == S_MUL) begin
      px_q <= 35'(qry_q.dx) * 35'(n_ext);
      pz_q <= 35'(qry_q.dz) * 35'(n_ext);
    end
    if ((state_q == S_RES) && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (cnt_q == '0))
    else $error("ring not back at home position after scan");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) && !bt_busy && !bx_busy && !bz_busy) |=> (state_q == S_RES))
    else $error("divider completion not taken");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |->
      ((out_data_o.hit_t <= 17'd65536) && (out_data_o.normal_code <= 3'd4)))
    else $error("hit result out of range");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      ((out_data_o.hit_slot == '0) && (out_data_o.hit_t == '0) &&
       (out_data_o.normal_code == '0)))
    else $error("miss result not cleared");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for nearest_ray_box_hit: box writes and ray queries in,
// one hit record out per transaction, compared with an in-bench slab predictor.
// Depends on nrbh_pkg and the nearest_ray_box_hit RTL.
module tb_top;
  import nrbh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = 64;
  localparam int MAX_CYCLES = 2000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_t in_data;
  out_t out_data;
  logic [TileW-1:0] cfg_data;

  nearest_ray_box_hit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // predictor state
  longint tile;
  bit live_tbl[NSLOT];
  longint cx_tbl[NSLOT], cz_tbl[NSLOT], fl_tbl[NSLOT];
  bit written[NSLOT];

  // generator-side copy of box positions, to aim rays
  logic signed [15:0] cx_shadow[NSLOT], cz_shadow[NSLOT];
  logic signed [7:0] fl_shadow[NSLOT];

  in_t pending_items[$];
  out_t expected_hits[$];
  int errors = 0;
  int cycles = 0;
  bit src_idle_en = 1, snk_idle_en = 1;
  int sink_hold = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint hit_point(longint s, longint d, longint n, longint den);
    longint r;
    r = fdiv(2 * (s * den + d * n) + den, 2 * den);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic bit slab_clip(longint s2, longint c2, longint d2, normal_e lo_c,
                                   normal_e hi_c, inout longint tn, inout longint td,
                                   inout longint xn, inout longint xd, inout normal_e nrm);
    longint lo, hi, den, n1, n2, tmp;
    normal_e c;
    lo = c2 - tile;
    hi = c2 + tile;
    if (d2 == 0) return !(s2 < lo || s2 > hi);
    den = d2 < 0 ? -d2 : d2;
    n1 = lo - s2;
    n2 = hi - s2;
    c = lo_c;
    if (d2 < 0) begin
      n1 = -n1;
      n2 = -n2;
    end
    if (n1 > n2) begin
      tmp = n1; n1 = n2; n2 = tmp; c = hi_c;
    end
    if (n1 * td > tn * den) begin
      tn = n1; td = den; nrm = c;
    end
    if (n2 * xd < xn * den) begin
      xn = n2; xd = den;
    end
    return 1;
  endfunction

  function automatic out_t nearest_hit(in_t it);
    out_t r;
    longint sx, sz, dx, dz, fl, tn, td, xn, xd, bn, bd;
    normal_e nrm, bnrm;
    bit found;
    int bslot;
    r = '0;
    if (it.req_type == REQ_WRITE) begin
      live_tbl[it.slot_index] = it.slot_live;
      cx_tbl[it.slot_index] = it.box_x;
      cz_tbl[it.slot_index] = it.box_z;
      fl_tbl[it.slot_index] = it.floor_id;
      written[it.slot_index] = 1;
      return r;
    end
    fl = it.floor_id;
    sx = it.start_x;
    sz = it.start_z;
    dx = longint'(it.end_x) - sx;
    dz = longint'(it.end_z) - sz;
    if (dx == 0 && dz == 0) return r;
    found = 0; bn = 0; bd = 1; bslot = 0; bnrm = NRM_NONE;
    for (int i = 0; i < NSLOT; i++) begin
      tn = 0; td = 1; xn = 1; xd = 1; nrm = NRM_NONE;
      if (!live_tbl[i] || fl_tbl[i] != fl) continue;
      if (!slab_clip(2 * sx, 2 * cx_tbl[i], 2 * dx, NRM_XN, NRM_XP, tn, td, xn, xd, nrm))
        continue;
      if (!slab_clip(2 * sz, 2 * cz_tbl[i], 2 * dz, NRM_ZN, NRM_ZP, tn, td, xn, xd, nrm))
        continue;
      if (xn * td < tn * xd) continue;
      if (!found || tn * bd < bn * td) begin
        found = 1; bslot = i; bnrm = nrm; bn = tn; bd = td;
      end
    end
    if (found) begin
      r.hit = 1;
      r.hit_slot = 6'(bslot);
      r.hit_t = 17'(fdiv(bn * 131072 + bd, 2 * bd));
      r.hit_x = 16'(hit_point(sx, dx, bn, bd));
      r.hit_z = 16'(hit_point(sz, dz, bn, bd));
      r.normal_code = bnrm;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) expected_hits.push_back(nearest_hit(in_data));
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && !(src_idle_en && $urandom_range(99) < 19)) begin
          in_valid <= 1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor and sink
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected transaction %p", out_data);
          errors++;
        end else begin
          out_t e;
          e = expected_hits.pop_front();
          if (out_data.hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, out_data.hit); errors++;
          end
          if (out_data.hit_slot !== e.hit_slot) begin
            $error("hit_slot exp %0d got %0d", e.hit_slot, out_data.hit_slot); errors++;
          end
          if (out_data.hit_t !== e.hit_t) begin
            $error("hit_t exp %0d got %0d", e.hit_t, out_data.hit_t); errors++;
          end
          if (out_data.hit_x !== e.hit_x) begin
            $error("hit_x exp %0d got %0d", e.hit_x, out_data.hit_x); errors++;
          end
          if (out_data.hit_z !== e.hit_z) begin
            $error("hit_z exp %0d got %0d", e.hit_z, out_data.hit_z); errors++;
          end
          if (out_data.normal_code !== e.normal_code) begin
            $error("normal_code exp %0d got %0d", e.normal_code, out_data.normal_code);
            errors++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_ready <= 0;
      end else begin
        out_ready <= !(snk_idle_en && $urandom_range(99) < 19);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t box_write(int slot, bit lv, logic signed [15:0] x,
                                    logic signed [15:0] z, logic signed [7:0] f);
    in_t it;
    it = '0;
    it.req_type = REQ_WRITE;
    it.slot_index = 6'(slot);
    it.slot_live = lv;
    it.box_x = x;
    it.box_z = z;
    it.floor_id = f;
    it.start_x = 16'($urandom);
    it.start_z = 16'($urandom);
    it.end_x = 16'($urandom);
    it.end_z = 16'($urandom);
    return it;
  endfunction

  function automatic in_t ray(logic signed [7:0] f, logic signed [15:0] sx,
                              logic signed [15:0] sz, logic signed [15:0] ex,
                              logic signed [15:0] ez);
    in_t it;
    it = '0;
    it.req_type = REQ_QUERY;
    it.slot_index = 6'($urandom);
    it.slot_live = 1'($urandom);
    it.box_x = 16'($urandom);
    it.box_z = 16'($urandom);
    it.floor_id = f;
    it.start_x = sx;
    it.start_z = sz;
    it.end_x = ex;
    it.end_z = ez;
    return it;
  endfunction

  // random item: a box write, or a ray aimed near a stored box of the queried floor most of the time
  function automatic in_t random_item();
    int s, span;
    logic signed [15:0] cx, cz;
    if ($urandom_range(99) < 30) begin
      s = $urandom_range(NSLOT - 1);
      span = $urandom_range(3) == 0 ? 32767 : 2048;
      return box_write(s, $urandom_range(9) != 0,
                       span > 4000 ? rnd16() : 16'($signed($urandom_range(4095)) - 2048),
                       span > 4000 ? rnd16() : 16'($signed($urandom_range(4095)) - 2048),
                       8'($urandom_range(9) == 0 ? $urandom : $urandom_range(2)));
    end
    s = $urandom_range(NSLOT - 1);
    if (written[s] && $urandom_range(9) < 8) begin
      cx = cx_shadow[s];
      cz = cz_shadow[s];
      return ray(fl_shadow[s],
                 cx + 16'($signed($urandom_range(2047)) - 1024),
                 cz + 16'($signed($urandom_range(2047)) - 1024),
                 $urandom_range(4) == 0 ? cx : cx + 16'($signed($urandom_range(2047)) - 1024),
                 $urandom_range(4) == 0 ? cz : cz + 16'($signed($urandom_range(2047)) - 1024));
    end
    return ray(8'($urandom_range(5) == 0 ? $urandom : $urandom_range(2)),
               rnd16(), rnd16(), rnd16(), rnd16());
  endfunction

  task automatic queue_item(in_t it);
    if (it.req_type == REQ_WRITE) begin
      cx_shadow[it.slot_index] = it.box_x;
      cz_shadow[it.slot_index] = it.box_z;
      fl_shadow[it.slot_index] = it.floor_id;
      written[it.slot_index] = 1;
    end
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_tile(logic [TileW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tile = v;
    cfg_valid <= 0;
  endtask

  initial begin
    logic [TileW-1:0] tiles[6];
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    tile = TileRst;
    foreach (written[i]) written[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: corners, faces, axis-parallel, zero length, ties, floor extremes
    queue_item(box_write(0, 1, 16'sd0, 16'sd0, 8'sd0));
    queue_item(box_write(1, 1, 16'sd1024, 16'sd0, 8'sd0));
    queue_item(box_write(2, 1, 16'sd1024, 16'sd0, 8'sd0));
    queue_item(box_write(63, 1, 16'sh7fff, 16'sh8000, -8'sd128));
    queue_item(box_write(5, 1, 16'sh8000, 16'sh7fff, 8'sd127));
    queue_item(ray(8'sd0, -16'sd1000, 16'sd0, 16'sd2000, 16'sd0));
    queue_item(ray(8'sd0, 16'sd2000, 16'sd0, -16'sd1000, 16'sd0));
    queue_item(ray(8'sd0, 16'sd0, -16'sd1000, 16'sd0, 16'sd1000));
    queue_item(ray(8'sd0, 16'sd0, 16'sd1000, 16'sd0, -16'sd1000));
    queue_item(ray(8'sd0, -16'sd500, -16'sd500, 16'sd500, 16'sd500));
    queue_item(ray(8'sd0, 16'sd10, 16'sd10, 16'sd50, 16'sd20));
    queue_item(ray(8'sd0, 16'sd5, 16'sd5, 16'sd5, 16'sd5));
    queue_item(ray(8'sd0, -16'sd500, 16'sd128, 16'sd2000, 16'sd128));
    queue_item(ray(8'sd0, -16'sd500, 16'sd129, 16'sd2000, 16'sd129));
    queue_item(ray(8'sd0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff));
    queue_item(ray(-8'sd128, 16'sh7000, 16'sh8000, 16'sh7fff, 16'sh8000));
    queue_item(ray(8'sd127, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7000));
    queue_item(ray(8'sd0, 16'sh8000, 16'sd0, 16'sh7fff, 16'sd0));
    queue_item(box_write(1, 0, 16'sd0, 16'sd0, 8'sd0));
    queue_item(ray(8'sd0, -16'sd500, 16'sd0, 16'sd2000, 16'sd0));
    drain();

    tiles = '{15'd1, 15'h7fff, 15'd0, 15'd3, 15'd777, TileRst};
    foreach (tiles[p]) begin
      set_tile(tiles[p]);
      if (p == 1) snk_idle_en = 0;
      if (p == 2) src_idle_en = 0;
      for (int k = 0; k < 250; k++) queue_item(random_item());
      if (p == 3) begin
        sink_hold = 2000;
        src_idle_en = 1;
        snk_idle_en = 1;
      end
      drain();
    end
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/nrbh_pkg.sv
rtl/nrbh_cell.sv
rtl/nrbh_slab.sv
rtl/nrbh_div.sv
rtl/nearest_ray_box_hit.sv
bench/tb_top.sv
